[rtl/core/adc_ladder_button_debouncer_defines.svh]
// Assertion macros used by the port-level checker of the ladder button decoder.
`ifndef ADC_LADDER_BUTTON_DEBOUNCER_DEFINES_SVH
`define ADC_LADDER_BUTTON_DEBOUNCER_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define ALDB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aldb assertion failed");

// Clocked assertion that also holds across reset.
`define ALDB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("aldb assertion failed");

`endif

[rtl/core/aldb_pkg.sv]
// Types, constants and helpers shared by the ladder button decoder.
package aldb_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DEC_W      = 3;
  localparam int CODE_W     = 2;

  localparam int MAX_BUTTONS         = 3;
  localparam int NUM_BUTTONS_DEFAULT = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BELOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_HIGH     = 3'd5;

  // Register values after reset.
  localparam logic [TICK_W-1:0]   RST_DEBOUNCE_TICKS = 16'd100;
  localparam logic [SAMPLE_W-1:0] RST_FIRST_BELOW    = 10'd10;
  localparam logic [SAMPLE_W-1:0] RST_SECOND_LOW     = 10'd320;
  localparam logic [SAMPLE_W-1:0] RST_SECOND_HIGH    = 10'd360;
  localparam logic [SAMPLE_W-1:0] RST_THIRD_LOW      = 10'd500;
  localparam logic [SAMPLE_W-1:0] RST_THIRD_HIGH     = 10'd530;

  // Decoded button codes.
  localparam logic signed [DEC_W-1:0] DEC_NONE    = -3'sd1;
  localparam logic signed [DEC_W-1:0] DEC_BUTTON0 = 3'sd0;
  localparam logic signed [DEC_W-1:0] DEC_BUTTON1 = 3'sd1;
  localparam logic signed [DEC_W-1:0] DEC_BUTTON2 = 3'sd2;

  // Reported state codes.
  localparam logic [CODE_W-1:0] CODE_WAITING      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DETECTED     = 2'd1;
  localparam logic [CODE_W-1:0] CODE_WAIT_RELEASE = 2'd2;
  localparam logic [CODE_W-1:0] CODE_UPDATE       = 2'd3;

  typedef enum logic [3:0] {
    PH_WAITING      = 4'b0001,
    PH_DETECTED     = 4'b0010,
    PH_WAIT_RELEASE = 4'b0100,
    PH_UPDATE       = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first_below;
    logic [SAMPLE_W-1:0] second_low;
    logic [SAMPLE_W-1:0] second_high;
    logic [SAMPLE_W-1:0] third_low;
    logic [SAMPLE_W-1:0] third_high;
  } win_cfg_t;

  function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
    logic [CODE_W-1:0] code;
    case (ph)
      PH_WAITING:      code = CODE_WAITING;
      PH_DETECTED:     code = CODE_DETECTED;
      PH_WAIT_RELEASE: code = CODE_WAIT_RELEASE;
      PH_UPDATE:       code = CODE_UPDATE;
      default:         code = CODE_WAITING;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/aldb_decode.sv]
// Window decoder that maps one ladder sample to a button index.
module aldb_decode (
  input  logic [aldb_pkg::SAMPLE_W-1:0]   sample,
  input  aldb_pkg::win_cfg_t              win,
  output logic signed [aldb_pkg::DEC_W-1:0] button
);

  // Windows are tested in button order; the first match wins.
  always_comb begin
    if (sample < win.first_below) begin
      button = aldb_pkg::DEC_BUTTON0;
    end else if (sample > win.second_low && sample < win.second_high) begin
      button = aldb_pkg::DEC_BUTTON1;
    end else if (sample > win.third_low && sample < win.third_high) begin
      button = aldb_pkg::DEC_BUTTON2;
    end else begin
      button = aldb_pkg::DEC_NONE;
    end
  end

endmodule

[rtl/core/aldb_button.sv]
// Debounce state machine for one ladder button.
module aldb_button (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [aldb_pkg::TICK_W-1:0]   now,
  input  logic                          pressed,
  input  logic [aldb_pkg::TICK_W-1:0]   debounce_ticks,
  output logic [aldb_pkg::CODE_W-1:0]   code_next
);

  aldb_pkg::phase_t              phase;
  aldb_pkg::phase_t              phase_next;
  logic [aldb_pkg::TICK_W-1:0]   stamp;
  logic [aldb_pkg::TICK_W-1:0]   stamp_next;
  logic [aldb_pkg::TICK_W-1:0]   elapsed;

  // The detected level is always "pressed", so staying pressed is the only
  // way to stay in the detected state. The difference wraps modulo 2^16.
  assign elapsed = now - stamp;

  always_comb begin
    phase_next = phase;
    stamp_next = stamp;
    case (phase)
      aldb_pkg::PH_WAITING: begin
        if (pressed) begin
          phase_next = aldb_pkg::PH_DETECTED;
          stamp_next = now;
        end
      end
      aldb_pkg::PH_DETECTED: begin
        if (!pressed) begin
          phase_next = aldb_pkg::PH_WAITING;
        end else if (elapsed > debounce_ticks) begin
          phase_next = aldb_pkg::PH_WAIT_RELEASE;
        end
      end
      aldb_pkg::PH_WAIT_RELEASE: begin
        if (!pressed) begin
          phase_next = aldb_pkg::PH_UPDATE;
        end
      end
      aldb_pkg::PH_UPDATE: begin
        phase_next = aldb_pkg::PH_WAITING;
      end
      default: begin
        phase_next = aldb_pkg::PH_WAITING;
      end
    endcase
  end

  assign code_next = aldb_pkg::phase_code(phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= aldb_pkg::PH_WAITING;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stamp <= stamp_next;
    end
  end

endmodule

[rtl/core/adc_ladder_button_debouncer.sv]
// Top level of the resistor-ladder button decoder with per-button debounce.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   input    | in_valid / in_ready     | raw_sample
//   output   | out_valid / out_ready   | decoded_button, state_zero,
//            |                         | state_one, state_two, press_events
//   config   | cfg_wr_en (no wait)     | cfg_index, cfg_data
//
// One transaction is taken in every cycle while the output is not stalled.
// A sample lands in the input register, and once the result register is
// empty or draining, the window decode and all button state machines update
// in one pass into the result register.
// Reset is synchronous and restores the register defaults, the tick counter
// and every button to waiting; there is no clearing pass.
// A stalled output holds its result, and a full input register then stalls the
// input; it takes a new transaction as soon as the result register drains.
module adc_ladder_button_debouncer #(
  parameter int NUM_BUTTONS = aldb_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input samples.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [aldb_pkg::SAMPLE_W-1:0]          raw_sample,
  // Results.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [aldb_pkg::DEC_W-1:0]      decoded_button,
  output logic [aldb_pkg::CODE_W-1:0]            state_zero,
  output logic [aldb_pkg::CODE_W-1:0]            state_one,
  output logic [aldb_pkg::CODE_W-1:0]            state_two,
  output logic [aldb_pkg::MAX_BUTTONS-1:0]       press_events,
  // Configuration writes.
  input  logic                                   cfg_wr_en,
  input  logic [aldb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [aldb_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // Configuration registers.
  logic [aldb_pkg::TICK_W-1:0] debounce_ticks;
  aldb_pkg::win_cfg_t          win;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks  <= aldb_pkg::RST_DEBOUNCE_TICKS;
      win.first_below <= aldb_pkg::RST_FIRST_BELOW;
      win.second_low  <= aldb_pkg::RST_SECOND_LOW;
      win.second_high <= aldb_pkg::RST_SECOND_HIGH;
      win.third_low   <= aldb_pkg::RST_THIRD_LOW;
      win.third_high  <= aldb_pkg::RST_THIRD_HIGH;
    end else if (cfg_wr_en) begin
      // Window bounds keep only the low sample-width bits of the data.
      case (cfg_index)
        aldb_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        aldb_pkg::REG_FIRST_BELOW:
          win.first_below <= cfg_data[aldb_pkg::SAMPLE_W-1:0];
        aldb_pkg::REG_SECOND_LOW:
          win.second_low <= cfg_data[aldb_pkg::SAMPLE_W-1:0];
        aldb_pkg::REG_SECOND_HIGH:
          win.second_high <= cfg_data[aldb_pkg::SAMPLE_W-1:0];
        aldb_pkg::REG_THIRD_LOW:
          win.third_low <= cfg_data[aldb_pkg::SAMPLE_W-1:0];
        aldb_pkg::REG_THIRD_HIGH:
          win.third_high <= cfg_data[aldb_pkg::SAMPLE_W-1:0];
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // Input register. It advances into the result register whenever that
  // register is empty or is being drained in the same cycle.
  logic                          s1_valid;
  logic [aldb_pkg::SAMPLE_W-1:0] s1_sample;
  logic                          advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= raw_sample;
    end
  end

  // Tick value that the sample in the input register will see. The counter
  // steps each time a sample advances into the result register, so after reset
  // the first sample sees a tick of one.
  logic [aldb_pkg::TICK_W-1:0] now_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_tick <= aldb_pkg::TICK_W'(1);
    end else if (advance) begin
      now_tick <= now_tick + aldb_pkg::TICK_W'(1);
    end
  end

  // Window decode of the sample in the input register.
  logic signed [aldb_pkg::DEC_W-1:0] dec;

  aldb_decode u_decode (
    .sample (s1_sample),
    .win    (win),
    .button (dec)
  );

  // One debounce machine per populated button; absent buttons report
  // waiting and never raise an event.
  logic [aldb_pkg::CODE_W-1:0]      code_next [aldb_pkg::MAX_BUTTONS];
  logic [aldb_pkg::MAX_BUTTONS-1:0] events_next;

  for (genvar b = 0; b < aldb_pkg::MAX_BUTTONS; b++) begin : g_button
    if (b < NUM_BUTTONS) begin : g_live
      aldb_button u_button (
        .clk            (clk),
        .rst            (rst),
        .advance        (advance),
        .now            (now_tick),
        .pressed        (dec == aldb_pkg::DEC_W'(b)),
        .debounce_ticks (debounce_ticks),
        .code_next      (code_next[b])
      );
    end else begin : g_absent
      assign code_next[b] = aldb_pkg::CODE_WAITING;
    end
    assign events_next[b] = (code_next[b] == aldb_pkg::CODE_UPDATE);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      decoded_button <= dec;
      state_zero     <= code_next[0];
      state_one      <= code_next[1];
      state_two      <= code_next[2];
      press_events   <= events_next;
    end
  end

endmodule

[rtl/core/aldb_checker.sv]
// Port-level checker for the ladder button decoder, bound to the top level.
`include "adc_ladder_button_debouncer_defines.svh"

module aldb_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [aldb_pkg::DEC_W-1:0]   decoded_button,
  input logic [aldb_pkg::CODE_W-1:0]         state_zero,
  input logic [aldb_pkg::CODE_W-1:0]         state_one,
  input logic [aldb_pkg::CODE_W-1:0]         state_two,
  input logic [aldb_pkg::MAX_BUTTONS-1:0]    press_events
);

  logic [aldb_pkg::MAX_BUTTONS-1:0] update_mask;
  logic                             decode_legal;
  logic [aldb_pkg::DEC_W+3*aldb_pkg::CODE_W+aldb_pkg::MAX_BUTTONS-1:0] result_bits;

  assign update_mask = {state_two == aldb_pkg::CODE_UPDATE,
                        state_one == aldb_pkg::CODE_UPDATE,
                        state_zero == aldb_pkg::CODE_UPDATE};

  assign decode_legal = (decoded_button == aldb_pkg::DEC_NONE)
                     || (decoded_button == aldb_pkg::DEC_BUTTON0)
                     || (decoded_button == aldb_pkg::DEC_BUTTON1)
                     || (decoded_button == aldb_pkg::DEC_BUTTON2);

  assign result_bits = {decoded_button, state_zero, state_one, state_two, press_events};

  // The event mask must agree with the reported button states.
  `ALDB_ASSERT(a_events_match_states, out_valid |-> press_events == update_mask)

  // Only button indexes or the no-match code may be reported.
  `ALDB_ASSERT(a_decode_legal, out_valid |-> decode_legal)

  // A reset leaves no result pending.
  `ALDB_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid)

  // A stalled result stays presented and unchanged.
  `ALDB_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(result_bits))

  // With no result pending the input side can always take a transaction.
  `ALDB_ASSERT(a_ready_when_drained, !out_valid |-> in_ready)

endmodule

bind adc_ladder_button_debouncer aldb_checker u_aldb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .decoded_button (decoded_button),
  .state_zero     (state_zero),
  .state_one      (state_one),
  .state_two      (state_two),
  .press_events   (press_events)
);

[dv/aldb_result_checker.sv]
// Result predictor and scoreboard for the resistor-ladder button decoder.
module aldb_result_checker #(
  parameter int NUM_BUTTONS = aldb_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [aldb_pkg::SAMPLE_W-1:0]        raw_sample,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [aldb_pkg::DEC_W-1:0]    decoded_button,
  input  logic [aldb_pkg::CODE_W-1:0]          state_zero,
  input  logic [aldb_pkg::CODE_W-1:0]          state_one,
  input  logic [aldb_pkg::CODE_W-1:0]          state_two,
  input  logic [aldb_pkg::MAX_BUTTONS-1:0]     press_events,
  input  logic                                 cfg_wr_en,
  input  logic [aldb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aldb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   failures,
  output int                                   awaiting
);
  import aldb_pkg::*;

  typedef struct packed {
    logic signed [DEC_W-1:0]                button;
    logic [MAX_BUTTONS-1:0][CODE_W-1:0]     states;
    logic [MAX_BUTTONS-1:0]                 events;
  } ladder_result_t;

  logic [TICK_W-1:0] debounce_limit;
  win_cfg_t          windows;
  logic [TICK_W-1:0] tick_now;
  logic [CODE_W-1:0] btn_code [MAX_BUTTONS];
  logic [TICK_W-1:0] press_stamp [MAX_BUTTONS];
  logic              latched_level [MAX_BUTTONS];

  ladder_result_t expected_results [$];
  int fail_tally = 0;
  int result_index = 0;

  // Advances the tick, decodes one sample and steps every populated debounce machine.
  task automatic debounce_step(input logic [SAMPLE_W-1:0] s, output ladder_result_t r);
    logic signed [DEC_W-1:0] hit;
    logic pressed;
    logic [TICK_W-1:0] held;
    tick_now = tick_now + 1'b1;
    // Windows are tried in button order, so the first match wins.
    if (s < windows.first_below) hit = DEC_BUTTON0;
    else if (s > windows.second_low && s < windows.second_high) hit = DEC_BUTTON1;
    else if (s > windows.third_low && s < windows.third_high) hit = DEC_BUTTON2;
    else hit = DEC_NONE;
    r = '0;
    r.button = hit;
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      if (b < NUM_BUTTONS) begin
        pressed = (hit == DEC_W'(b));
        case (btn_code[b])
          CODE_WAITING: begin
            if (pressed) begin
              btn_code[b]       = CODE_DETECTED;
              press_stamp[b]    = tick_now;
              latched_level[b]  = 1'b1;
            end
          end
          CODE_DETECTED: begin
            if (latched_level[b] == pressed) begin
              // Elapsed time is taken modulo the tick width.
              held = tick_now - press_stamp[b];
              if (held > debounce_limit) btn_code[b] = CODE_WAIT_RELEASE;
            end else begin
              btn_code[b] = CODE_WAITING;
            end
          end
          CODE_WAIT_RELEASE: begin
            if (!pressed) btn_code[b] = CODE_UPDATE;
          end
          default: begin
            btn_code[b]      = CODE_WAITING;
            press_stamp[b]   = tick_now;
            latched_level[b] = 1'b0;
          end
        endcase
        r.states[b] = btn_code[b];
        r.events[b] = (btn_code[b] == CODE_UPDATE);
      end
    end
  endtask

  always @(posedge clk) begin
    ladder_result_t fresh;
    ladder_result_t oldest;
    ladder_result_t got;
    if (rst) begin
      debounce_limit       = RST_DEBOUNCE_TICKS;
      windows.first_below  = RST_FIRST_BELOW;
      windows.second_low   = RST_SECOND_LOW;
      windows.second_high  = RST_SECOND_HIGH;
      windows.third_low    = RST_THIRD_LOW;
      windows.third_high   = RST_THIRD_HIGH;
      tick_now             = '0;
      for (int b = 0; b < MAX_BUTTONS; b++) begin
        btn_code[b]      = CODE_WAITING;
        press_stamp[b]   = '0;
        latched_level[b] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DEBOUNCE_TICKS: debounce_limit      = cfg_data;
          REG_FIRST_BELOW:    windows.first_below = cfg_data[SAMPLE_W-1:0];
          REG_SECOND_LOW:     windows.second_low  = cfg_data[SAMPLE_W-1:0];
          REG_SECOND_HIGH:    windows.second_high = cfg_data[SAMPLE_W-1:0];
          REG_THIRD_LOW:      windows.third_low   = cfg_data[SAMPLE_W-1:0];
          REG_THIRD_HIGH:     windows.third_high  = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        debounce_step(raw_sample, fresh);
        expected_results.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        got.button    = decoded_button;
        got.states[0] = state_zero;
        got.states[1] = state_one;
        got.states[2] = state_two;
        got.events    = press_events;
        if (expected_results.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("result %0d arrived with nothing expected: button %0d events %b",
                     result_index, got.button, got.events);
        end else begin
          oldest = expected_results.pop_front();
          if (got.button !== oldest.button || got.states[0] !== oldest.states[0] ||
              got.states[1] !== oldest.states[1] || got.states[2] !== oldest.states[2] ||
              got.events !== oldest.events) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("result %0d mismatch: expected button %0d states %0d/%0d/%0d events %b, got button %0d states %0d/%0d/%0d events %b",
                       result_index, oldest.button, oldest.states[0], oldest.states[1],
                       oldest.states[2], oldest.events, got.button, got.states[0],
                       got.states[1], got.states[2], got.events);
          end
        end
        result_index++;
      end
    end
    failures <= fail_tally;
    awaiting <= expected_results.size();
  end

endmodule

[dv/tb_adc_ladder_button_debouncer.sv]
// Stimulus and verdict for the resistor-ladder button decoder testbench.
module tb_adc_ladder_button_debouncer;
  import aldb_pkg::*;

  // The slowest correct run stays far below this, even with the heavy
  // idling phases and the long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [SAMPLE_W-1:0]         raw_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [DEC_W-1:0]     decoded_button;
  logic [CODE_W-1:0]           state_zero;
  logic [CODE_W-1:0]           state_one;
  logic [CODE_W-1:0]           state_two;
  logic [MAX_BUTTONS-1:0]      press_events;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int          failures;
  int          awaiting;
  int unsigned cycle_count = 0;
  int unsigned sent_total = 0;

  // Idling percentages of the two sides. The sender's value is only used by
  // the stimulus process; the receiver's is read by its own process.
  int send_idle_pct = 20;
  int recv_idle_pct = 87;

  // Long receiver hold-off, requested once by the stimulus.
  logic pressure_go = 1'b0;
  logic hold_recv = 1'b0;

  // Copies of the register values last written, used to aim samples at the
  // button windows.
  logic [TICK_W-1:0]   cur_deb = RST_DEBOUNCE_TICKS;
  logic [SAMPLE_W-1:0] cur_fb  = RST_FIRST_BELOW;
  logic [SAMPLE_W-1:0] cur_sl  = RST_SECOND_LOW;
  logic [SAMPLE_W-1:0] cur_sh  = RST_SECOND_HIGH;
  logic [SAMPLE_W-1:0] cur_tl  = RST_THIRD_LOW;
  logic [SAMPLE_W-1:0] cur_th  = RST_THIRD_HIGH;

  adc_ladder_button_debouncer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_button (decoded_button),
    .state_zero     (state_zero),
    .state_one      (state_one),
    .state_two      (state_two),
    .press_events   (press_events),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  aldb_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_button (decoded_button),
    .state_zero     (state_zero),
    .state_one      (state_one),
    .state_two      (state_two),
    .press_events   (press_events),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .failures       (failures),
    .awaiting       (awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off if it hangs, for example on a handshake that never
  // completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** adc_ladder_button_debouncer: FAILED **");
      $finish;
    end
  end

  // The receiver drops ready at random, and holds it low throughout the
  // long hold-off.
  always @(posedge clk) begin
    out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // The hold-off is counted here so that the sender keeps offering samples
  // meanwhile; the block fills up and must stall its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_recv <= 1'b1;
    repeat (300) @(posedge clk);
    hold_recv <= 1'b0;
  end

  // Offers one sample and returns at the edge where the transaction happens.
  // Valid is only lowered for an idle cycle, so it never drops and rises
  // within one time step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
  endtask

  // Waits until every expected result has come back, then lets the two-stage
  // pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all registers. The upper bits of the narrow registers carry noise
  // that the block must drop, and the two unused indexes get random data.
  task automatic program_ladder(input logic [TICK_W-1:0] deb, input logic [SAMPLE_W-1:0] fb,
                                input logic [SAMPLE_W-1:0] sl, input logic [SAMPLE_W-1:0] sh,
                                input logic [SAMPLE_W-1:0] tl, input logic [SAMPLE_W-1:0] th);
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_FIRST_BELOW, {6'($urandom), fb});
    write_reg(REG_SECOND_LOW, {6'($urandom), sl});
    write_reg(REG_SECOND_HIGH, {6'($urandom), sh});
    write_reg(REG_THIRD_LOW, {6'($urandom), tl});
    write_reg(REG_THIRD_HIGH, {6'($urandom), th});
    write_reg(REG_UNUSED_LOW, 16'($urandom));
    write_reg(REG_UNUSED_HIGH, 16'($urandom));
    cfg_wr_en <= 1'b0;
    cur_deb = deb;
    cur_fb  = fb;
    cur_sl  = sl;
    cur_sh  = sh;
    cur_tl  = tl;
    cur_th  = th;
  endtask

  // A sample at or above every bound matches no window, whatever the setting.
  function automatic logic [SAMPLE_W-1:0] quiet_sample();
    int unsigned hi_bound;
    hi_bound = cur_fb;
    if (cur_sh > hi_bound) hi_bound = cur_sh;
    if (cur_th > hi_bound) hi_bound = cur_th;
    return SAMPLE_W'($urandom_range(hi_bound, 1023));
  endfunction

  // A sample inside the window of one button, or a quiet one when that
  // window is empty.
  function automatic logic [SAMPLE_W-1:0] sample_in(input int unsigned b);
    case (b)
      0: begin
        if (cur_fb != 0) return SAMPLE_W'($urandom_range(cur_fb - 1));
      end
      1: begin
        if (int'(cur_sh) > int'(cur_sl) + 1)
          return SAMPLE_W'($urandom_range(cur_sl + 1, cur_sh - 1));
      end
      default: begin
        if (int'(cur_th) > int'(cur_tl) + 1)
          return SAMPLE_W'($urandom_range(cur_tl + 1, cur_th - 1));
      end
    endcase
    return quiet_sample();
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] boundary_samples [13] = '{
      10'd0, 10'd9, 10'd10, 10'd320, 10'd321, 10'd359, 10'd360,
      10'd500, 10'd501, 10'd529, 10'd530, 10'd1023, 10'd512
    };
    logic [SAMPLE_W-1:0] overlap_samples [8] = '{
      10'd50, 10'd50, 10'd1023, 10'd650, 10'd650, 10'd650, 10'd750, 10'd1023
    };
    logic [SAMPLE_W-1:0] empty_samples [4] = '{10'd400, 10'd401, 10'd950, 10'd0};
    logic [TICK_W-1:0]   deb;
    logic [SAMPLE_W-1:0] fb, sl, sh, tl, th;
    int unsigned         phase_start, btn, hold;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: every window bound from both
    // sides, plus the top and bottom of the sample range.
    foreach (boundary_samples[i]) send_sample(boundary_samples[i]);

    // Overlapping windows: button 0 beats 1, and 1 beats 2. With no debounce
    // a press is taken on its second sample.
    settle();
    program_ladder(16'd0, 10'd600, 10'd0, 10'd700, 10'd100, 10'd800);
    foreach (overlap_samples[i]) send_sample(overlap_samples[i]);

    // Empty windows: equal bounds and a low bound above its high bound.
    settle();
    program_ladder(16'd2, 10'd0, 10'd400, 10'd400, 10'd900, 10'd100);
    foreach (empty_samples[i]) send_sample(empty_samples[i]);

    // Random phases. Most of the traffic is presses held around the debounce
    // time, some with a bounce inside, then released; the rest is noise.
    for (int p = 0; p < 11; p++) begin
      settle();
      if (p == 4) begin
        send_idle_pct = 87;
        recv_idle_pct <= 20;
      end
      if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      deb = 16'($urandom_range(12));
      fb  = 10'($urandom_range(1, 120));
      sl  = 10'($urandom_range(150, 400));
      sh  = sl + 10'($urandom_range(2, 80));
      tl  = 10'($urandom_range(sh, 700));
      th  = tl + 10'($urandom_range(2, 200));
      case (p)
        0: deb = 16'd0;
        1: deb = 16'hFFFF;
        2: begin
          fb = 10'd0;
          sl = 10'd0;
          sh = 10'd1023;
          tl = 10'd1023;
          th = 10'd0;
        end
        3: begin
          fb = 10'd1023;
          sl = 10'd1023;
          sh = 10'd0;
          tl = 10'd0;
          th = 10'd1023;
        end
        4: begin
          deb = RST_DEBOUNCE_TICKS;
          fb  = RST_FIRST_BELOW;
          sl  = RST_SECOND_LOW;
          sh  = RST_SECOND_HIGH;
          tl  = RST_THIRD_LOW;
          th  = RST_THIRD_HIGH;
        end
        5: begin
          fb = 10'($urandom);
          sl = 10'($urandom);
          sh = 10'($urandom);
          tl = 10'($urandom);
          th = 10'($urandom);
        end
        default: ;
      endcase
      program_ladder(deb, fb, sl, sh, tl, th);
      if (p == 9) pressure_go <= 1'b1;

      phase_start = sent_total;
      while (sent_total - phase_start < 150) begin
        if ($urandom_range(99) < 15) begin
          send_sample(10'($urandom));
        end else begin
          btn  = $urandom_range(2);
          hold = (cur_deb <= 16'd120) ? $urandom_range(cur_deb + 4) : $urandom_range(1, 12);
          for (int i = 0; i < hold; i++) begin
            if ($urandom_range(99) < 5)
              send_sample($urandom_range(1) ? quiet_sample() : sample_in($urandom_range(2)));
            else
              send_sample(sample_in(btn));
          end
          repeat ($urandom_range(1, 3)) send_sample(quiet_sample());
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (failures == 0 && awaiting == 0) begin
      $display("** adc_ladder_button_debouncer: PASSED **");
    end else begin
      $display("** adc_ladder_button_debouncer: FAILED **");
    end
    $finish;
  end

endmodule
